// ----- rtl/pit_pkg.sv -----
// ============================================================================
// pit_pkg
// Shared types and codes for the presence interval tracker.
// ============================================================================
package pit_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 328;

    localparam logic [1:0] ACT_OBSERVE = 2'd0;
    localparam logic [1:0] ACT_SWEEP   = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Which result the output register takes when a transaction completes.
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2,
        RES_ENTRY = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     idx_inc;
        logic     wr_new;
        logic     wr_hit;
        logic     wr_sweep;
        logic     load_result;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       count_zero;
        logic       idx_last;
        logic       hit;
        logic       hit_active;
        logic       full;
        logic       read_miss;
        logic       out_busy;
    } sts_t;

endpackage

// ----- rtl/pit_ctrl.sv -----
// ============================================================================
// pit_ctrl
// Sequencer for observe scans, sweeps and reads.
// ============================================================================
module pit_ctrl
    import pit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_OBS_CMP  = 8'b0000_0100,
        S_OBS_WAIT = 8'b0000_1000,
        S_NEW      = 8'b0001_0000,
        S_SWP_MOD  = 8'b0010_0000,
        S_SWP_WAIT = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t   state_reg, state_next;
    res_sel_t res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= RES_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res_sel = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_next   = RES_ZERO;
                state_next = S_FINISH;
                priority if (sts.act == ACT_OBSERVE)
                begin
                    state_next = sts.count_zero ? S_NEW : S_OBS_CMP;
                end
                else if (sts.act == ACT_SWEEP)
                begin
                    if (!sts.count_zero)
                        state_next = S_SWP_MOD;
                end
                else if (sts.act == ACT_READ)
                begin
                    res_next = sts.read_miss ? RES_EMPTY : RES_ENTRY;
                end
                else
                begin
                    // An unknown action only reports an ok status.
                    state_next = S_FINISH;
                end
            end
            S_OBS_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.wr_hit = sts.hit_active;
                    state_next = S_FINISH;
                end
                else if (sts.idx_last)
                    state_next = S_NEW;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_OBS_WAIT;
                end
            end
            S_OBS_WAIT:
                state_next = S_OBS_CMP;
            S_NEW:
            begin
                if (sts.full)
                    res_next = RES_FULL;
                else
                    cmd.wr_new = 1'b1;
                state_next = S_FINISH;
            end
            S_SWP_MOD:
            begin
                cmd.wr_sweep = 1'b1;
                if (sts.idx_last)
                    state_next = S_FINISH;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SWP_WAIT;
                end
            end
            S_SWP_WAIT:
                state_next = S_SWP_MOD;
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/pit_datapath.sv -----
// ============================================================================
// pit_datapath
// Slot memories, scan index, fill count and result register.
// ============================================================================
module pit_datapath
    import pit_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > 10) ? CW : 10;

    // Slot stores; only slots below the fill count are ever read back.
    logic [63:0] key_mem    [TABLE_DEPTH];
    logic [31:0] ffrm_mem   [TABLE_DEPTH];
    logic [31:0] lfrm_mem   [TABLE_DEPTH];
    logic [95:0] fpos_mem   [TABLE_DEPTH];
    logic [95:0] lpos_mem   [TABLE_DEPTH];
    logic [1:0]  flag_mem   [TABLE_DEPTH];  // bit 1 closed, bit 0 seen

    logic [63:0] key_rd;
    logic [31:0] ffrm_rd, lfrm_rd;
    logic [95:0] fpos_rd, lpos_rd;
    logic [1:0]  flag_rd;

    logic [1:0]  act_reg;
    logic [63:0] id_reg;
    logic [31:0] frame_reg;
    logic [95:0] pos_reg;
    logic        miss_reg;

    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]            out_user_reg;

    logic [9:0]    in_index;
    logic [AW-1:0] wr_addr;

    assign in_index = s_tdata[201:192];
    assign wr_addr  = cmd.wr_new ? count_reg[AW-1:0] : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= s_tuser;
            id_reg    <= s_tdata[63:0];
            frame_reg <= s_tdata[95:64];
            pos_reg   <= s_tdata[191:96];
            miss_reg  <= (XW'(in_index) >= XW'(count_reg));
        end
    end

    // Memory writes and registered reads at the scan index.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_new)
        begin
            key_mem[wr_addr]  <= id_reg;
            ffrm_mem[wr_addr] <= frame_reg;
            fpos_mem[wr_addr] <= pos_reg;
        end
        if (cmd.wr_new || cmd.wr_hit)
        begin
            lfrm_mem[wr_addr] <= frame_reg;
            lpos_mem[wr_addr] <= pos_reg;
        end
        if (cmd.wr_new || cmd.wr_hit)
            flag_mem[wr_addr] <= 2'b01;
        else if (cmd.wr_sweep)
            flag_mem[wr_addr] <= {flag_rd[1] | ~flag_rd[0], 1'b0};
        key_rd     <= key_mem[idx_reg];
        ffrm_rd    <= ffrm_mem[idx_reg];
        lfrm_rd    <= lfrm_mem[idx_reg];
        fpos_rd    <= fpos_mem[idx_reg];
        lpos_rd    <= lpos_mem[idx_reg];
        flag_rd    <= flag_mem[idx_reg];
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.capture)
            idx_next = (s_tuser == ACT_READ) ? AW'(in_index) : '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + AW'(1);
    end

    assign count_next = cmd.wr_new ? count_reg + CW'(1) : count_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            unique case (cmd.res_sel)
                RES_ZERO:
                begin
                    out_user_reg <= ST_OK;
                    out_data_reg <= '0;
                end
                RES_FULL:
                begin
                    out_user_reg <= ST_FULL;
                    out_data_reg <= '0;
                end
                RES_EMPTY:
                begin
                    out_user_reg <= ST_EMPTY;
                    out_data_reg <= '0;
                end
                RES_ENTRY:
                begin
                    out_user_reg <= ST_OK;
                    out_data_reg <= {7'd0, lpos_rd[95:64], lpos_rd[63:32], lpos_rd[31:0],
                                     fpos_rd[95:64], fpos_rd[63:32], fpos_rd[31:0],
                                     lfrm_rd, ffrm_rd,
                                     key_rd, flag_rd[1]};
                end
                default:
                begin
                    out_user_reg <= ST_OK;
                    out_data_reg <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        sts            = '0;
        sts.act        = act_reg;
        sts.count_zero = (count_reg == '0);
        sts.idx_last   = ((CW'(idx_reg) + CW'(1)) == count_reg);
        sts.hit        = (key_rd == id_reg);
        sts.hit_active = ~flag_rd[1];
        sts.full       = (count_reg == CW'(TABLE_DEPTH));
        sts.read_miss  = miss_reg;
        sts.out_busy   = out_valid_reg & ~m_tready;
    end

endmodule

// ----- rtl/presence_interval_tracker.sv -----
// ============================================================================
// presence_interval_tracker
// Table of 64-bit object ids recording first and last sighting of each.
// ============================================================================
// A read dispatches on the captured index and finishes; an observe scans the
// keys from slot 0 until a hit, else adds the new id unless the table is full;
// a sweep updates the flags of every filled slot. One transaction at a time:
// the linear key scan over one registered memory read port sets the rate.
// The result register lets a new transaction start while a result waits.
// Reset clears the fill count and control state only; no clearing pass.
module presence_interval_tracker
    import pit_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: object_id[63:0], frame_number[95:64], pos_x_bits[127:96],
    // pos_y_bits[159:128], pos_z_bits[191:160], entry_index[201:192], zero pad.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: entry_closed[0], out_object_id[64:1], first_frame[96:65],
    // last_frame[128:97], first_x[160:129], first_y[192:161], first_z[224:193],
    // last_x[256:225], last_y[288:257], last_z[320:289], zero pad.
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]            m_tuser
);

    cmd_t cmd;
    sts_t sts;

    // The controller only sequences; every slot store lives in the datapath.
    pit_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pit_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // At most one kind of table write in a cycle.
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_new, cmd.wr_hit, cmd.wr_sweep}))
        else $error("conflicting table writes");

    // A new entry is never written into a full table.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_new |-> !sts.full)
        else $error("entry written into full table");

    // A loaded result is presented on the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> m_tvalid)
        else $error("result lost after load");

    // No table write happens while a new transaction can be accepted.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(cmd.wr_new || cmd.wr_hit || cmd.wr_sweep))
        else $error("table write while idle");

endmodule
